// File: rtl/rau_pkg.sv
// rau_pkg: shared constants, operation codes and types for the rational
// arithmetic unit. No dependencies.
`timescale 1ns / 1ps

package rau_pkg;

  // default operand width and internal datapath widths
  localparam int OPERAND_WIDTH = 16;
  localparam int CALC_W        = 64;   // intermediates wrap modulo 2^64
  localparam int FRAC_W        = 33;   // canonical numerator / denominator
  localparam int NUM_W         = 33;   // result numerator field
  localparam int DEN_W         = 31;   // result denominator field
  localparam int CNT_W         = $clog2(CALC_W + 1);

  typedef enum logic [2:0] {
    FUNC_ADD = 3'd0,
    FUNC_SUB = 3'd1,
    FUNC_MUL = 3'd2,
    FUNC_DIV = 3'd3,
    FUNC_RED = 3'd4,
    FUNC_CMP = 3'd5
  } func_e;

  typedef enum logic [1:0] {
    ORD_LESS    = 2'd0,
    ORD_EQUAL   = 2'd1,
    ORD_GREATER = 2'd2
  } order_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DEN = 2'd1,
    ST_DIV_ZERO = 2'd2
  } status_e;

  // control broadcast along the divider cell row
  typedef struct packed {
    logic load;   // clear remainder bits
    logic step;   // shift and trial subtract
    logic keep;   // trial difference did not borrow
  } cell_ctl_t;

endpackage

// File: rtl/rau_if.sv
// rau_if: valid/ready channel interfaces for operand and result transactions.
// Depends on rau_pkg.
`timescale 1ns / 1ps

interface rau_in_if #(
  parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH
);
  logic                            valid;
  logic                            ready;
  logic [2:0]                      func;
  logic signed [OPERAND_WIDTH-1:0] a_num;
  logic signed [OPERAND_WIDTH-1:0] a_den;
  logic signed [OPERAND_WIDTH-1:0] b_num;
  logic signed [OPERAND_WIDTH-1:0] b_den;

  modport source (output valid, func, a_num, a_den, b_num, b_den, input ready);
  modport sink   (input valid, func, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_out_if;
  logic                            valid;
  logic                            ready;
  logic signed [rau_pkg::NUM_W-1:0] res_num;
  logic [rau_pkg::DEN_W-1:0]        res_den;
  logic [1:0]                      order;
  logic [1:0]                      status;

  modport source (output valid, res_num, res_den, order, status, input ready);
  modport sink   (input valid, res_num, res_den, order, status, output ready);
endinterface

// File: rtl/rau_div_cell.sv
// rau_div_cell: one bit slice of the restoring divider remainder.
// Depends on rau_pkg.
`timescale 1ns / 1ps

module rau_div_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rau_pkg::cell_ctl_t ctl_i,
  input  logic               shift_i,   // bit handed over by lower neighbour
  input  logic               dvs_i,     // divisor bit of this slice
  input  logic               borrow_i,
  output logic               borrow_o,
  output logic               rem_o
);

  logic rem_d, rem_q;
  logic diff;

  // full subtractor on the shifted bit
  assign diff     = shift_i ^ dvs_i ^ borrow_i;
  assign borrow_o = (~shift_i & dvs_i) | (~(shift_i ^ dvs_i) & borrow_i);

  always_comb begin
    rem_d = rem_q;
    if (ctl_i.load) begin
      rem_d = 1'b0;
    end else if (ctl_i.step) begin
      rem_d = ctl_i.keep ? diff : shift_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= 1'b0;
    end else begin
      rem_q <= rem_d;
    end
  end

  assign rem_o = rem_q;

endmodule

// File: rtl/rau_divider.sv
// rau_divider: bit-serial restoring divider built from a row of rau_div_cell
// slices, one quotient bit per cycle. Depends on rau_pkg, rau_div_cell.
`timescale 1ns / 1ps

module rau_divider (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [rau_pkg::CALC_W-1:0] dividend_i,
  input  logic [rau_pkg::CALC_W-1:0] divisor_i,
  output logic                       done_o,
  output logic [rau_pkg::CALC_W-1:0] quot_o
);

  localparam int N = rau_pkg::CALC_W;

  logic [N-1:0]              qsr_q;    // dividend in, quotient out
  logic [N-1:0]              dvs_q;
  logic [rau_pkg::CNT_W-1:0] cnt_q;
  logic                      busy_q;
  logic                      done_q;

  logic [N:0]   rem;
  logic [N+1:0] borrow;
  logic [N:0]   dvs_ext;
  rau_pkg::cell_ctl_t ctl;

  assign dvs_ext   = {1'b0, dvs_q};
  assign borrow[0] = 1'b0;
  assign ctl.load  = start_i;
  assign ctl.step  = busy_q;
  assign ctl.keep  = ~borrow[N+1];

  // remainder slices, shifted up by one each step
  for (genvar i = 0; i <= N; i++) begin : g_cell
    logic shift_in;
    if (i == 0) begin : g_low
      assign shift_in = qsr_q[N-1];
    end else begin : g_up
      assign shift_in = rem[i-1];
    end
    rau_div_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctl_i    (ctl),
      .shift_i  (shift_in),
      .dvs_i    (dvs_ext[i]),
      .borrow_i (borrow[i]),
      .borrow_o (borrow[i+1]),
      .rem_o    (rem[i])
    );
  end

  // quotient shift register and step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        qsr_q  <= dividend_i;
        dvs_q  <= divisor_i;
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        qsr_q <= {qsr_q[N-2:0], ctl.keep};
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == rau_pkg::CNT_W'(N - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = qsr_q;

endmodule

// File: rtl/rau_gcd.sv
// rau_gcd: iterative binary GCD, one reduction step per cycle.
// Depends on rau_pkg.
`timescale 1ns / 1ps

module rau_gcd (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [rau_pkg::CALC_W-1:0] x_i,
  input  logic [rau_pkg::CALC_W-1:0] y_i,
  output logic                       done_o,
  output logic [rau_pkg::CALC_W-1:0] gcd_o
);

  logic [rau_pkg::CALC_W-1:0] x_q, y_q, g_q;
  logic [rau_pkg::CNT_W-1:0]  k_q;     // common factors of two
  logic                       busy_q, done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        x_q    <= x_i;
        y_q    <= y_i;
        k_q    <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        if (x_q == '0) begin
          g_q    <= y_q << k_q;
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else if (y_q == '0) begin
          g_q    <= x_q << k_q;
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          case ({x_q[0], y_q[0]})
            2'b00: begin
              x_q <= x_q >> 1;
              y_q <= y_q >> 1;
              k_q <= k_q + 1'b1;
            end
            2'b01: x_q <= x_q >> 1;
            2'b10: y_q <= y_q >> 1;
            default: begin
              if (x_q >= y_q) begin
                x_q <= (x_q - y_q) >> 1;
              end else begin
                y_q <= (y_q - x_q) >> 1;
              end
            end
          endcase
        end
      end
    end
  end

  assign done_o = done_q;
  assign gcd_o  = g_q;

endmodule

// File: rtl/rational_arith_unit.sv
// Rational arithmetic unit: one transaction in flight; operand a, operand b
// (for add, subtract, multiply, divide and compare) and the result of add,
// subtract, multiply and divide are canonicalised through a shared binary
// GCD and a bit-serial divider, with the cross products formed in turn on
// one multiplier. A zero denominator skips to the result with a status. A new
// transaction is accepted only once idle again. Output is registered.
// Reset (rst_ni low, asynchronous) returns to idle with no result pending.
`timescale 1ns / 1ps

module rational_arith_unit #(
  parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH
) (
  input logic       clk_i,
  input logic       rst_ni,
  rau_in_if.sink    in_i,
  rau_out_if.source out_o
);

  localparam int CW = rau_pkg::CALC_W;
  localparam int FW = rau_pkg::FRAC_W;

  typedef enum logic [3:0] {
    S_IDLE, S_SETUP, S_GCD_GO, S_GCD_WAIT, S_DIVN_GO, S_DIVN_WAIT,
    S_DIVD_GO, S_DIVD_WAIT, S_CN_DONE, S_MUL, S_COMB, S_FIN
  } state_e;

  typedef enum logic [1:0] {PH_A, PH_B, PH_R} phase_e;

  state_e            state_q;
  phase_e            phase_q;
  rau_pkg::func_e    func_q;
  logic [CW-1:0]     b_num_raw_q, b_den_raw_q;
  logic [CW-1:0]     cn_num_q, cn_den_q;      // fraction to canonicalise
  logic              cn_neg_q;
  logic [CW-1:0]     cn_mag_q, cn_dv_q, g_q, qn_q;
  logic signed [FW-1:0] a_num_q, a_den_q, b_num_q, b_den_q;
  logic [CW-1:0]     p_q, q_q, d_q;
  logic [1:0]        mstep_q;
  logic [CW-1:0]     res_num_q, res_den_q;
  rau_pkg::order_e   ord_q;
  rau_pkg::status_e  st_q;
  logic              out_valid_q;
  logic signed [rau_pkg::NUM_W-1:0] out_num_q;
  logic [rau_pkg::DEN_W-1:0]        out_den_q;
  logic [1:0]        out_ord_q, out_st_q;

  // sign extension of the operand fields
  logic [CW-1:0] in_an, in_ad, in_bn, in_bd;
  assign in_an = {{(CW-OPERAND_WIDTH){in_i.a_num[OPERAND_WIDTH-1]}}, in_i.a_num};
  assign in_ad = {{(CW-OPERAND_WIDTH){in_i.a_den[OPERAND_WIDTH-1]}}, in_i.a_den};
  assign in_bn = {{(CW-OPERAND_WIDTH){in_i.b_num[OPERAND_WIDTH-1]}}, in_i.b_num};
  assign in_bd = {{(CW-OPERAND_WIDTH){in_i.b_den[OPERAND_WIDTH-1]}}, in_i.b_den};

  // denominator sign fix and numerator magnitude
  logic [CW-1:0] fx_num, fx_den, fx_mag;
  logic          fx_neg;
  assign fx_num = cn_den_q[CW-1] ? (CW'(0) - cn_num_q) : cn_num_q;
  assign fx_den = cn_den_q[CW-1] ? (CW'(0) - cn_den_q) : cn_den_q;
  assign fx_neg = fx_num[CW-1];
  assign fx_mag = fx_neg ? (CW'(0) - fx_num) : fx_num;

  // shared GCD and divider
  logic          gcd_done, div_done;
  logic [CW-1:0] gcd_val, div_quot;

  rau_gcd u_gcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == S_GCD_GO),
    .x_i     (cn_mag_q),
    .y_i     (cn_dv_q),
    .done_o  (gcd_done),
    .gcd_o   (gcd_val)
  );

  rau_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    ((state_q == S_DIVN_GO) || (state_q == S_DIVD_GO)),
    .dividend_i ((state_q == S_DIVN_GO) ? cn_mag_q : cn_dv_q),
    .divisor_i  (g_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // canonical result of the current pass
  logic [CW-1:0] cn_res_num;
  assign cn_res_num = cn_neg_q ? (CW'(0) - qn_q) : qn_q;

  // cross-product operand selection
  logic signed [FW-1:0]   mul_a, mul_b;
  logic signed [2*FW-1:0] prod;
  always_comb begin
    case (mstep_q)
      2'd0: begin
        mul_a = a_num_q;
        mul_b = (func_q == rau_pkg::FUNC_MUL) ? b_num_q : b_den_q;
      end
      2'd1: begin
        mul_a = b_num_q;
        mul_b = a_den_q;
      end
      default: begin
        mul_a = a_den_q;
        mul_b = (func_q == rau_pkg::FUNC_DIV) ? b_num_q : b_den_q;
      end
    endcase
  end
  assign prod = mul_a * mul_b;

  logic [CW-1:0] cross_diff;
  assign cross_diff = p_q - q_q;

  logic known_func;
  assign known_func = (func_q == rau_pkg::FUNC_ADD) || (func_q == rau_pkg::FUNC_SUB) ||
                      (func_q == rau_pkg::FUNC_MUL) || (func_q == rau_pkg::FUNC_DIV) ||
                      (func_q == rau_pkg::FUNC_CMP);

  // sequencer and registered output
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= PH_A;
      mstep_q     <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_o.ready && (state_q != S_FIN)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            func_q      <= rau_pkg::func_e'(in_i.func);
            b_num_raw_q <= in_bn;
            b_den_raw_q <= in_bd;
            ord_q       <= rau_pkg::ORD_LESS;
            res_num_q   <= '0;
            if ((in_ad == '0) ||
                ((in_i.func != rau_pkg::FUNC_RED) && (in_bd == '0))) begin
              st_q      <= rau_pkg::ST_ZERO_DEN;
              res_den_q <= '0;
              state_q   <= S_FIN;
            end else begin
              st_q      <= rau_pkg::ST_OK;
              res_den_q <= CW'(1);
              cn_num_q  <= in_an;
              cn_den_q  <= in_ad;
              phase_q   <= PH_A;
              state_q   <= S_SETUP;
            end
          end
        end
        S_SETUP: begin
          cn_neg_q <= fx_neg;
          cn_mag_q <= fx_mag;
          cn_dv_q  <= fx_den;
          state_q  <= S_GCD_GO;
        end
        S_GCD_GO: state_q <= S_GCD_WAIT;
        S_GCD_WAIT: begin
          if (gcd_done) begin
            g_q     <= (gcd_val == '0) ? CW'(1) : gcd_val;
            state_q <= S_DIVN_GO;
          end
        end
        S_DIVN_GO: state_q <= S_DIVN_WAIT;
        S_DIVN_WAIT: begin
          if (div_done) begin
            qn_q    <= div_quot;
            state_q <= S_DIVD_GO;
          end
        end
        S_DIVD_GO: state_q <= S_DIVD_WAIT;
        S_DIVD_WAIT: begin
          if (div_done) begin
            state_q <= S_CN_DONE;
          end
        end
        S_CN_DONE: begin
          case (phase_q)
            PH_A: begin
              a_num_q <= cn_res_num[FW-1:0];
              a_den_q <= div_quot[FW-1:0];
              if (func_q == rau_pkg::FUNC_RED) begin
                res_num_q <= cn_res_num;
                res_den_q <= div_quot;
                state_q   <= S_FIN;
              end else if (!known_func) begin
                state_q <= S_FIN;
              end else begin
                cn_num_q <= b_num_raw_q;
                cn_den_q <= b_den_raw_q;
                phase_q  <= PH_B;
                state_q  <= S_SETUP;
              end
            end
            PH_B: begin
              b_num_q <= cn_res_num[FW-1:0];
              b_den_q <= div_quot[FW-1:0];
              if ((func_q == rau_pkg::FUNC_DIV) && (qn_q == '0)) begin
                st_q      <= rau_pkg::ST_DIV_ZERO;
                res_den_q <= '0;
                state_q   <= S_FIN;
              end else begin
                mstep_q <= 2'd0;
                state_q <= S_MUL;
              end
            end
            default: begin
              res_num_q <= cn_res_num;
              res_den_q <= div_quot;
              state_q   <= S_FIN;
            end
          endcase
        end
        S_MUL: begin
          mstep_q <= mstep_q + 2'd1;
          case (mstep_q)
            2'd0: p_q <= prod[CW-1:0];
            2'd1: q_q <= prod[CW-1:0];
            default: begin
              d_q     <= prod[CW-1:0];
              state_q <= S_COMB;
            end
          endcase
        end
        S_COMB: begin
          if (func_q == rau_pkg::FUNC_CMP) begin
            // compare: sign of the cross-product difference
            if (cross_diff == '0) begin
              ord_q <= rau_pkg::ORD_EQUAL;
            end else if (cross_diff[CW-1]) begin
              ord_q <= rau_pkg::ORD_LESS;
            end else begin
              ord_q <= rau_pkg::ORD_GREATER;
            end
            state_q <= S_FIN;
          end else begin
            cn_den_q <= d_q;
            phase_q  <= PH_R;
            state_q  <= S_SETUP;
            case (func_q)
              rau_pkg::FUNC_ADD: cn_num_q <= p_q + q_q;
              rau_pkg::FUNC_SUB: cn_num_q <= cross_diff;
              default:           cn_num_q <= p_q;   // multiply and divide
            endcase
          end
        end
        S_FIN: begin
          if (!out_valid_q || out_o.ready) begin
            out_num_q   <= res_num_q[rau_pkg::NUM_W-1:0];
            out_den_q   <= res_den_q[rau_pkg::DEN_W-1:0];
            out_ord_q   <= ord_q;
            out_st_q    <= st_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_i.ready    = (state_q == S_IDLE);
  assign out_o.valid   = out_valid_q;
  assign out_o.res_num = out_num_q;
  assign out_o.res_den = out_den_q;
  assign out_o.order   = out_ord_q;
  assign out_o.status  = out_st_q;

endmodule

// File: dv/tb_if.sv
// Testbench-side note: the channel interfaces come from rtl/rau_if.sv.
// This file only gives the checker's result record; depends on rau_pkg.
`timescale 1ns / 1ps

package tb_rau_pkg;

  // one expected result transaction
  typedef struct packed {
    logic signed [rau_pkg::NUM_W-1:0] num;
    logic [rau_pkg::DEN_W-1:0]        den;
    logic [1:0]                       ord;
    logic [1:0]                       st;
  } fraction_result_t;
endpackage

// File: dv/testbench.sv
// Testbench for rational_arith_unit: drives operand transactions with random
// bursts and gaps, predicts each reduced fraction or comparison, and checks
// every result in order. Depends on rau_pkg, rau_if and tb_rau_pkg.
`timescale 1ns / 1ps

module testbench;

  localparam int W = rau_pkg::OPERAND_WIDTH;
  localparam int IDLE_LIMIT = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  bit   failed = 1'b0;
  int   idle_cycles = 0;
  tb_rau_pkg::fraction_result_t expected_results[$];

  rau_in_if #(.OPERAND_WIDTH(W)) op_ch ();
  rau_out_if res_ch ();

  rational_arith_unit #(.OPERAND_WIDTH(W)) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (op_ch.sink),
    .out_o (res_ch.source)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // --- predictor: 64-bit wrapping arithmetic, Euclidean reduction ---
  function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
    logic [63:0] r;
    while (y != 64'd0) begin
      r = x % y;
      x = y;
      y = r;
    end
    return x;
  endfunction

  function automatic void reduce_frac(input logic [63:0] n, input logic [63:0] d,
                                      output logic [63:0] rn,
                                      output logic [63:0] rd);
    logic [63:0] mag, g;
    logic neg;
    if (d[63]) begin
      n = -n;
      d = -d;
    end
    neg = n[63];
    mag = neg ? -n : n;
    g = gcd64(mag, d);
    if (g == 64'd0) g = 64'd1;
    mag = mag / g;
    rn = neg ? -mag : mag;
    rd = d / g;
  endfunction

  function automatic tb_rau_pkg::fraction_result_t predict_fraction(
      logic [2:0] fn, logic [W-1:0] an_i, logic [W-1:0] ad_i,
      logic [W-1:0] bn_i, logic [W-1:0] bd_i);
    tb_rau_pkg::fraction_result_t res;
    logic [63:0] an, ad, bn, bd, xn, xd, yn, yd, rn, rd, p, q;
    an = {{(64-W){an_i[W-1]}}, an_i};
    ad = {{(64-W){ad_i[W-1]}}, ad_i};
    bn = {{(64-W){bn_i[W-1]}}, bn_i};
    bd = {{(64-W){bd_i[W-1]}}, bd_i};
    rn = 64'd0;
    rd = 64'd1;
    res.ord = rau_pkg::ORD_LESS;
    res.st = rau_pkg::ST_OK;
    if (ad == 64'd0 || (fn != rau_pkg::FUNC_RED && bd == 64'd0)) begin
      res.st = rau_pkg::ST_ZERO_DEN;
      rd = 64'd0;
    end else begin
      reduce_frac(an, ad, xn, xd);
      yn = xn;
      yd = xd;
      if (fn != rau_pkg::FUNC_RED) reduce_frac(bn, bd, yn, yd);
      case (fn)
        rau_pkg::FUNC_ADD, rau_pkg::FUNC_SUB: begin
          p = xn * yd;
          q = yn * xd;
          reduce_frac((fn == rau_pkg::FUNC_ADD) ? p + q : p - q, xd * yd, rn, rd);
        end
        rau_pkg::FUNC_MUL: reduce_frac(xn * yn, xd * yd, rn, rd);
        rau_pkg::FUNC_DIV: begin
          if (yn == 64'd0) begin
            res.st = rau_pkg::ST_DIV_ZERO;
            rd = 64'd0;
          end else begin
            reduce_frac(xn * yd, xd * yn, rn, rd);
          end
        end
        rau_pkg::FUNC_RED: begin
          rn = xn;
          rd = xd;
        end
        rau_pkg::FUNC_CMP: begin
          p = xn * yd - yn * xd;
          res.ord = (p == 64'd0) ? rau_pkg::ORD_EQUAL
                                 : (p[63] ? rau_pkg::ORD_LESS : rau_pkg::ORD_GREATER);
        end
        default: ;
      endcase
    end
    res.num = rn[rau_pkg::NUM_W-1:0];
    res.den = rd[rau_pkg::DEN_W-1:0];
    return res;
  endfunction

  // --- sender: one operand transaction, burst/gap pacing ---
  int burst_left = 0;

  task automatic send_operands(logic [2:0] fn, logic [W-1:0] an, logic [W-1:0] ad,
                               logic [W-1:0] bn, logic [W-1:0] bd);
    int gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 40));
      if (gap != 0) begin
        op_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    op_ch.valid <= 1'b1;
    op_ch.func  <= fn;
    op_ch.a_num <= an;
    op_ch.a_den <= ad;
    op_ch.b_num <= bn;
    op_ch.b_den <= bd;
    expected_results.push_back(predict_fraction(fn, an, ad, bn, bd));
    @(posedge clk_i);
    while (!op_ch.ready) @(posedge clk_i);
  endtask

  function automatic logic [W-1:0] pick_value();
    case ($urandom_range(0, 5))
      0: return {1'b1, {(W-1){1'b0}}};
      1: return {1'b0, {(W-1){1'b1}}};
      2: return W'($urandom_range(0, 12)) - W'(6);
      3: return W'($urandom_range(1, 30) * ($urandom_range(1, 8)));
      default: return W'($urandom);
    endcase
  endfunction

  // --- tests ---
  task automatic test_directed();
    logic [W-1:0] mn, mx;
    mn = {1'b1, {(W-1){1'b0}}};
    mx = {1'b0, {(W-1){1'b1}}};
    for (int f = 0; f < 8; f++) send_operands(3'(f), W'(3), W'(-6), W'(-5), W'(10));
    send_operands(rau_pkg::FUNC_ADD, mx, W'(1), mx, W'(1));
    send_operands(rau_pkg::FUNC_MUL, mn, mx, mn, mn);
    send_operands(rau_pkg::FUNC_SUB, mn, W'(1), mx, W'(-1));
    send_operands(rau_pkg::FUNC_DIV, mx, mn, mn, mx);
    send_operands(rau_pkg::FUNC_ADD, W'(1), W'(0), W'(1), W'(1));
    send_operands(rau_pkg::FUNC_ADD, W'(1), W'(1), W'(1), W'(0));
    send_operands(rau_pkg::FUNC_RED, W'(6), W'(4), W'(7), W'(0));
    send_operands(rau_pkg::FUNC_RED, W'(0), W'(-9), W'(0), W'(0));
    send_operands(rau_pkg::FUNC_DIV, W'(5), W'(3), W'(0), W'(-7));
    send_operands(rau_pkg::FUNC_CMP, W'(-2), W'(4), W'(1), W'(-2));
    send_operands(rau_pkg::FUNC_CMP, W'(1), W'(3), W'(1), W'(2));
    send_operands(rau_pkg::FUNC_SUB, W'(0), W'(5), W'(0), W'(-5));
    send_operands(rau_pkg::FUNC_MUL, W'(0), W'(-1), mn, W'(1));
  endtask

  task automatic wait_for_drain();
    @(negedge clk_i);
    op_ch.valid <= 1'b0;
    burst_left = 0;
    while (expected_results.size() != 0) @(negedge clk_i);
  endtask

  task automatic test_random(int count);
    logic [W-1:0] ad, bd;
    for (int i = 0; i < count; i++) begin
      ad = pick_value();
      bd = pick_value();
      if ($urandom_range(0, 30) != 0 && ad == '0) ad = W'(1);
      if ($urandom_range(0, 30) != 0 && bd == '0) bd = '1;
      send_operands(3'($urandom_range(0, 15) == 0 ? $urandom_range(6, 7)
                                                  : $urandom_range(0, 5)),
                    pick_value(), ad, pick_value(), bd);
      if (i == count / 2) wait_for_drain();
    end
  endtask

  // receiver stall pattern
  always @(negedge clk_i) begin
    if ($urandom_range(0, 199) < 100) res_ch.ready <= 1'b1;
    else res_ch.ready <= ($urandom_range(0, 2) != 0);
  end

  // result checker and watchdog
  always @(posedge clk_i) begin
    tb_rau_pkg::fraction_result_t exp_res;
    if (rst_ni) begin
      if ((op_ch.valid && op_ch.ready) || (res_ch.valid && res_ch.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (res_ch.valid && res_ch.ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result transaction");
          failed = 1'b1;
        end else begin
          exp_res = expected_results.pop_front();
          if (res_ch.res_num !== exp_res.num) begin
            $error("res_num exp %0d got %0d", exp_res.num, res_ch.res_num);
            failed = 1'b1;
          end
          if (res_ch.res_den !== exp_res.den) begin
            $error("res_den exp %0d got %0d", exp_res.den, res_ch.res_den);
            failed = 1'b1;
          end
          if (res_ch.order !== exp_res.ord) begin
            $error("order exp %0d got %0d", exp_res.ord, res_ch.order);
            failed = 1'b1;
          end
          if (res_ch.status !== exp_res.st) begin
            $error("status exp %0d got %0d", exp_res.st, res_ch.status);
            failed = 1'b1;
          end
        end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("rational_arith_unit test failed");
        $finish;
      end
    end
  end

  initial begin
    op_ch.valid = 1'b0;
    op_ch.func  = '0;
    op_ch.a_num = '0;
    op_ch.a_den = '0;
    op_ch.b_num = '0;
    op_ch.b_den = '0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_random(735);
    wait_for_drain();
    repeat (50) @(negedge clk_i);
    if (!failed && expected_results.size() == 0) begin
      $display("rational_arith_unit test passed");
    end else begin
      $display("rational_arith_unit test failed");
    end
    $finish;
  end
endmodule

// File: filelist.f
rtl/rau_pkg.sv
rtl/rau_if.sv
rtl/rau_div_cell.sv
rtl/rau_divider.sv
rtl/rau_gcd.sv
rtl/rational_arith_unit.sv
dv/tb_if.sv
dv/testbench.sv
